### rtl/axis_move_ramp_controller_defines.svh
// ----------------------------------------------------------------------------
// axis move ramp controller assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef AXIS_MOVE_RAMP_CONTROLLER_DEFINES_SVH
`define AXIS_MOVE_RAMP_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define AMRC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AMRC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/amrc_pkg.sv
// ----------------------------------------------------------------------------
// amrc_pkg
// types, constants and tables for the axis move ramp controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package amrc_pkg;

  localparam int AXES    = 3;
  localparam int AX_W    = 2;
  localparam int POS_W   = 32;
  localparam int STALL_W = 16;
  localparam int TENTH_W = 10;
  localparam int SPEED_W = 11;
  localparam int RAMP_IW = 7;
  // 1000 * progress needs ten more bits than a position difference
  localparam int NUM_W   = POS_W + TENTH_W;
  localparam int CNT_W   = $clog2(NUM_W);
  // wide enough for signed positions and the scaled numerator
  localparam int ALU_W   = NUM_W + 2;

  localparam logic [STALL_W-1:0] STALL_RESET = STALL_W'(100);
  localparam logic [STALL_W-1:0] STALL_MAX   = {STALL_W{1'b1}};
  localparam logic [TENTH_W-1:0] TENTH_FULL  = TENTH_W'(1000);
  localparam logic [TENTH_W-1:0] RAMP_LO     = TENTH_W'(100);
  localparam logic [TENTH_W-1:0] RAMP_HI     = TENTH_W'(900);

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_CANCEL = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MAG = 2'd2
  } alu_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TOTAL,
    S_DONE,
    S_STEP,
    S_CHECK,
    S_MUL1,
    S_MUL2,
    S_DIV,
    S_FSUM,
    S_FCMP,
    S_SPEED
  } state_e;

  typedef struct packed {
    alu_op_e            op;
    logic [ALU_W-1:0]   a;
    logic [ALU_W-1:0]   b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0]   res;
    logic               neg;
  } alu_rsp_t;

  // braking floor for step + (progress << k) beyond the move length
  function automatic logic [TENTH_W-1:0] floor_of(input logic [1:0] k);
    logic [TENTH_W-1:0] f;
    case (k)
      2'd0:    f = TENTH_W'(975);
      2'd1:    f = TENTH_W'(950);
      default: f = TENTH_W'(900);
    endcase
    return f;
  endfunction

  // sigmoid ramp, round(1000 / (1 + e^(7 - 0.14 d)))
  function automatic logic [TENTH_W-1:0] ramp(input logic [RAMP_IW-1:0] d);
    logic [TENTH_W-1:0] r;
    case (d)
      7'd0:  r = 10'd1;   7'd1:  r = 10'd1;   7'd2:  r = 10'd1;   7'd3:  r = 10'd1;
      7'd4:  r = 10'd2;   7'd5:  r = 10'd2;   7'd6:  r = 10'd2;   7'd7:  r = 10'd2;
      7'd8:  r = 10'd3;   7'd9:  r = 10'd3;   7'd10: r = 10'd4;   7'd11: r = 10'd4;
      7'd12: r = 10'd5;   7'd13: r = 10'd6;   7'd14: r = 10'd6;   7'd15: r = 10'd7;
      7'd16: r = 10'd8;   7'd17: r = 10'd10;  7'd18: r = 10'd11;  7'd19: r = 10'd13;
      7'd20: r = 10'd15;  7'd21: r = 10'd17;  7'd22: r = 10'd19;  7'd23: r = 10'd22;
      7'd24: r = 10'd26;  7'd25: r = 10'd29;  7'd26: r = 10'd34;  7'd27: r = 10'd38;
      7'd28: r = 10'd44;  7'd29: r = 10'd50;  7'd30: r = 10'd57;  7'd31: r = 10'd65;
      7'd32: r = 10'd74;  7'd33: r = 10'd85;  7'd34: r = 10'd96;  7'd35: r = 10'd109;
      7'd36: r = 10'd123; 7'd37: r = 10'd139; 7'd38: r = 10'd157; 7'd39: r = 10'd177;
      7'd40: r = 10'd198; 7'd41: r = 10'd221; 7'd42: r = 10'd246; 7'd43: r = 10'd273;
      7'd44: r = 10'd302; 7'd45: r = 10'd332; 7'd46: r = 10'd364; 7'd47: r = 10'd397;
      7'd48: r = 10'd430; 7'd49: r = 10'd465; 7'd50: r = 10'd500; 7'd51: r = 10'd535;
      7'd52: r = 10'd570; 7'd53: r = 10'd603; 7'd54: r = 10'd636; 7'd55: r = 10'd668;
      7'd56: r = 10'd698; 7'd57: r = 10'd727; 7'd58: r = 10'd754; 7'd59: r = 10'd779;
      7'd60: r = 10'd802; 7'd61: r = 10'd823; 7'd62: r = 10'd843; 7'd63: r = 10'd861;
      7'd64: r = 10'd877; 7'd65: r = 10'd891; 7'd66: r = 10'd904; 7'd67: r = 10'd915;
      7'd68: r = 10'd926; 7'd69: r = 10'd935; 7'd70: r = 10'd943; 7'd71: r = 10'd950;
      7'd72: r = 10'd956; 7'd73: r = 10'd962; 7'd74: r = 10'd966; 7'd75: r = 10'd971;
      7'd76: r = 10'd974; 7'd77: r = 10'd978; 7'd78: r = 10'd981; 7'd79: r = 10'd983;
      7'd80: r = 10'd985; 7'd81: r = 10'd987; 7'd82: r = 10'd989; 7'd83: r = 10'd990;
      7'd84: r = 10'd992; 7'd85: r = 10'd993; 7'd86: r = 10'd994; 7'd87: r = 10'd994;
      7'd88: r = 10'd995; 7'd89: r = 10'd996; 7'd90: r = 10'd996; 7'd91: r = 10'd997;
      7'd92: r = 10'd997; 7'd93: r = 10'd998; 7'd94: r = 10'd998; 7'd95: r = 10'd998;
      7'd96: r = 10'd998; 7'd97: r = 10'd999; 7'd98: r = 10'd999; 7'd99: r = 10'd999;
      default: r = 10'd1000;
    endcase
    return r;
  endfunction

endpackage

### rtl/amrc_in_if.sv
// ----------------------------------------------------------------------------
// amrc_in_if
// command channel: start move, position sample or cancel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface amrc_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         op;
  logic [amrc_pkg::AX_W-1:0]          axis;
  logic signed [amrc_pkg::POS_W-1:0]  position;
  logic signed [amrc_pkg::POS_W-1:0]  target;

  modport source (output valid, op, axis, position, target, input ready);
  modport sink   (input valid, op, axis, position, target, output ready);
endinterface

### rtl/amrc_out_if.sv
// ----------------------------------------------------------------------------
// amrc_out_if
// speed command channel, one transfer per sample on an active axis
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface amrc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [amrc_pkg::AX_W-1:0]            out_axis;
  logic signed [amrc_pkg::SPEED_W-1:0]  speed;
  logic                                 finished;

  modport source (output valid, out_axis, speed, finished, input ready);
  modport sink   (input valid, out_axis, speed, finished, output ready);
endinterface

### rtl/amrc_alu.sv
// ----------------------------------------------------------------------------
// amrc_alu
// shared add, subtract and absolute-difference unit with sign flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module amrc_alu (
  input  amrc_pkg::alu_req_t req_i,
  output amrc_pkg::alu_rsp_t rsp_o
);

  localparam int W = amrc_pkg::ALU_W;

  logic [W:0] diff;
  logic [W:0] rdiff;
  logic [W:0] sum;

  assign diff  = {req_i.a[W-1], req_i.a} - {req_i.b[W-1], req_i.b};
  assign rdiff = {req_i.b[W-1], req_i.b} - {req_i.a[W-1], req_i.a};
  assign sum   = {req_i.a[W-1], req_i.a} + {req_i.b[W-1], req_i.b};

  always_comb begin
    rsp_o.neg = diff[W];
    unique case (req_i.op)
      amrc_pkg::ALU_ADD: rsp_o.res = sum[W-1:0];
      amrc_pkg::ALU_SUB: rsp_o.res = diff[W-1:0];
      amrc_pkg::ALU_MAG: rsp_o.res = diff[W] ? rdiff[W-1:0] : diff[W-1:0];
      default:           rsp_o.res = diff[W-1:0];
    endcase
  end

endmodule

### rtl/axis_move_ramp_controller.sv
// ----------------------------------------------------------------------------
// axis move ramp controller: start and cancel are taken in idle, configuration by cfg_we_i
// a sample runs total, done, step and check, then speed if the move ends there,
// else mul, the 42-step restoring divider on the shared alu and floor steps first
// one item in flight, the result register frees the input side at once
// rst_ni clears active flags and stall counters, stall_limit resets to 100
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "axis_move_ramp_controller_defines.svh"

module axis_move_ramp_controller (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [amrc_pkg::STALL_W-1:0]          cfg_data_i,
  amrc_in_if.sink                               item_i,
  amrc_out_if.source                            result_o
);

  localparam int W  = amrc_pkg::ALU_W;
  localparam int PW = amrc_pkg::POS_W;
  localparam int TW = amrc_pkg::TENTH_W;
  localparam int NW = amrc_pkg::NUM_W;
  localparam int CW = amrc_pkg::CNT_W;
  localparam int SW = amrc_pkg::STALL_W;

  amrc_pkg::state_e state_q, state_d;

  logic [amrc_pkg::AXES-1:0]    active_q;
  logic [SW-1:0]                stall_cnt_q [amrc_pkg::AXES];
  logic [SW-1:0]                stall_limit_q;
  logic signed [PW-1:0]         start_q  [amrc_pkg::AXES];
  logic signed [PW-1:0]         target_q [amrc_pkg::AXES];
  logic signed [PW-1:0]         prev_q   [amrc_pkg::AXES];

  logic [amrc_pkg::AX_W-1:0]    ax_q;
  logic signed [PW-1:0]         pos_q;
  logic [PW-1:0]                total_q;
  logic [PW-1:0]                done_q;
  logic [PW-1:0]                step_q;
  logic                         up_q;
  logic                         fin_q;
  logic [NW-1:0]                num_q;
  logic [PW-1:0]                rem_q;
  logic [TW-1:0]                quo_q;
  logic [CW-1:0]                cnt_q;
  logic [1:0]                   k_q;
  logic [W-1:0]                 sum_q;
  logic [TW-1:0]                tenth_q;

  logic                         out_valid_q;
  logic [amrc_pkg::AX_W-1:0]    out_axis_q;
  logic signed [amrc_pkg::SPEED_W-1:0] out_speed_q;
  logic                         out_fin_q;

  amrc_pkg::alu_req_t           alu_req;
  amrc_pkg::alu_rsp_t           alu_rsp;

  logic                         accept;
  logic                         axis_ok;
  logic                         out_load;
  logic                         total_zero;
  logic                         stall_hit;
  logic [SW-1:0]                stall_inc;
  logic                         stall_end;
  logic [PW:0]                  trial;
  logic [TW-1:0]                fl;
  logic [TW-1:0]                ramp_mag;
  logic [TW-1:0]                ramp_back;

  amrc_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign item_i.ready = (state_q == amrc_pkg::S_IDLE);
  assign accept       = item_i.valid && item_i.ready;
  assign axis_ok      = (int'(item_i.axis) < amrc_pkg::AXES);
  assign out_load     = (state_q == amrc_pkg::S_SPEED) && (!out_valid_q || result_o.ready);

  assign total_zero = (total_q == '0);
  assign stall_hit  = (done_q != '0) && (step_q == '0);
  assign stall_inc  = (stall_cnt_q[ax_q] == amrc_pkg::STALL_MAX) ? amrc_pkg::STALL_MAX
                                                                 : stall_cnt_q[ax_q] + 1'b1;
  assign stall_end  = stall_hit && (stall_inc > stall_limit_q);
  assign trial      = {rem_q, num_q[NW-1]};
  assign fl         = amrc_pkg::floor_of(k_q);

  // ramp index counts from the nearer end of the move
  assign ramp_back = amrc_pkg::TENTH_FULL - tenth_q;
  always_comb begin
    if (tenth_q < amrc_pkg::RAMP_LO) begin
      ramp_mag = amrc_pkg::ramp(tenth_q[amrc_pkg::RAMP_IW-1:0]);
    end else if (tenth_q > amrc_pkg::RAMP_HI) begin
      ramp_mag = amrc_pkg::ramp(ramp_back[amrc_pkg::RAMP_IW-1:0]);
    end else begin
      ramp_mag = amrc_pkg::TENTH_FULL;
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    alu_req.op  = amrc_pkg::ALU_SUB;
    alu_req.a   = '0;
    alu_req.b   = '0;
    unique case (state_q)
      amrc_pkg::S_IDLE: begin
        if (accept && axis_ok && (item_i.op == amrc_pkg::OP_SAMPLE) &&
            active_q[item_i.axis]) begin
          state_d = amrc_pkg::S_TOTAL;
        end
      end
      amrc_pkg::S_TOTAL: begin
        // neg flag here means target above start
        alu_req.op = amrc_pkg::ALU_MAG;
        alu_req.a  = W'(start_q[ax_q]);
        alu_req.b  = W'(target_q[ax_q]);
        state_d    = amrc_pkg::S_DONE;
      end
      amrc_pkg::S_DONE: begin
        alu_req.op = amrc_pkg::ALU_MAG;
        alu_req.a  = W'(pos_q);
        alu_req.b  = W'(start_q[ax_q]);
        state_d    = amrc_pkg::S_STEP;
      end
      amrc_pkg::S_STEP: begin
        alu_req.op = amrc_pkg::ALU_MAG;
        alu_req.a  = W'(pos_q);
        alu_req.b  = W'(prev_q[ax_q]);
        state_d    = amrc_pkg::S_CHECK;
      end
      amrc_pkg::S_CHECK: begin
        // progress at or past the length, a zero length or a stall past the limit ends the move
        alu_req.a = W'(done_q);
        alu_req.b = W'(total_q);
        if (total_zero || stall_end || !alu_rsp.neg) begin
          state_d = amrc_pkg::S_SPEED;
        end else begin
          state_d = amrc_pkg::S_MUL1;
        end
      end
      amrc_pkg::S_MUL1: begin
        // 1000 * done as (done << 10) - (done << 4) - (done << 3)
        alu_req.a = W'({done_q, 10'b0});
        alu_req.b = W'({done_q, 4'b0});
        state_d   = amrc_pkg::S_MUL2;
      end
      amrc_pkg::S_MUL2: begin
        alu_req.a = sum_q;
        alu_req.b = W'({done_q, 3'b0});
        state_d   = amrc_pkg::S_DIV;
      end
      amrc_pkg::S_DIV: begin
        alu_req.a = W'(trial);
        alu_req.b = W'(total_q);
        if (cnt_q == CW'(NW - 1)) begin
          state_d = amrc_pkg::S_FSUM;
        end
      end
      amrc_pkg::S_FSUM: begin
        alu_req.op = amrc_pkg::ALU_ADD;
        alu_req.a  = W'(step_q);
        alu_req.b  = W'(done_q) << k_q;
        state_d    = amrc_pkg::S_FCMP;
      end
      amrc_pkg::S_FCMP: begin
        alu_req.a = W'(total_q);
        alu_req.b = sum_q;
        if (alu_rsp.neg || (k_q == 2'd2)) begin
          state_d = amrc_pkg::S_SPEED;
        end else begin
          state_d = amrc_pkg::S_FSUM;
        end
      end
      amrc_pkg::S_SPEED: begin
        if (out_load) begin
          state_d = amrc_pkg::S_IDLE;
        end
      end
      default: state_d = amrc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= amrc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_limit_q <= amrc_pkg::STALL_RESET;
    end else if (cfg_we_i) begin
      stall_limit_q <= cfg_data_i;
    end
  end

  // active flags and stall counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      for (int i = 0; i < amrc_pkg::AXES; i++) begin
        stall_cnt_q[i] <= '0;
      end
    end else begin
      if (accept) begin
        case (item_i.op)
          amrc_pkg::OP_START:  if (axis_ok) active_q[item_i.axis] <= 1'b1;
          amrc_pkg::OP_CANCEL: active_q <= '0;
          default: ;
        endcase
      end
      if ((state_q == amrc_pkg::S_CHECK) && !total_zero) begin
        stall_cnt_q[ax_q] <= stall_hit ? stall_inc : '0;
      end
      if (out_load && fin_q) begin
        active_q[ax_q] <= 1'b0;
      end
    end
  end

  // position stores
  always_ff @(posedge clk_i) begin
    if (accept && axis_ok && (item_i.op == amrc_pkg::OP_START)) begin
      start_q[item_i.axis]  <= item_i.position;
      prev_q[item_i.axis]   <= item_i.position;
      target_q[item_i.axis] <= item_i.target;
    end
    if (out_load) begin
      prev_q[ax_q] <= pos_q;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      amrc_pkg::S_IDLE: begin
        ax_q  <= item_i.axis;
        pos_q <= item_i.position;
        rem_q <= '0;
        quo_q <= '0;
        cnt_q <= '0;
        k_q   <= '0;
      end
      amrc_pkg::S_TOTAL: begin
        total_q <= alu_rsp.res[PW-1:0];
        up_q    <= alu_rsp.neg;
      end
      amrc_pkg::S_DONE:  done_q <= alu_rsp.res[PW-1:0];
      amrc_pkg::S_STEP:  step_q <= alu_rsp.res[PW-1:0];
      amrc_pkg::S_CHECK: fin_q  <= total_zero || stall_end || !alu_rsp.neg;
      amrc_pkg::S_MUL1:  sum_q  <= alu_rsp.res;
      amrc_pkg::S_MUL2:  num_q  <= alu_rsp.res[NW-1:0];
      amrc_pkg::S_DIV: begin
        // restoring step, quotient known to stay below 1000
        if (!alu_rsp.neg) begin
          rem_q <= alu_rsp.res[PW-1:0];
        end else begin
          rem_q <= trial[PW-1:0];
        end
        quo_q <= {quo_q[TW-2:0], !alu_rsp.neg};
        num_q <= {num_q[NW-2:0], 1'b0};
        cnt_q <= cnt_q + 1'b1;
      end
      amrc_pkg::S_FSUM: sum_q <= alu_rsp.res;
      amrc_pkg::S_FCMP: begin
        k_q <= k_q + 1'b1;
        if (alu_rsp.neg && (quo_q < fl)) begin
          tenth_q <= fl;
        end else begin
          tenth_q <= quo_q;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_axis_q <= ax_q;
      out_fin_q  <= fin_q;
      if (fin_q) begin
        out_speed_q <= '0;
      end else if (up_q) begin
        out_speed_q <= signed'({1'b0, ramp_mag});
      end else begin
        out_speed_q <= -signed'({1'b0, ramp_mag});
      end
    end
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.out_axis = out_axis_q;
  assign result_o.speed    = out_speed_q;
  assign result_o.finished = out_fin_q;

  `AMRC_ASSERT_IMP(a_fin_zero, result_o.valid && result_o.finished, result_o.speed == '0,
                   "finished transfer with nonzero speed")
  `AMRC_ASSERT_IMP(a_run_moving, result_o.valid && !result_o.finished, result_o.speed != '0,
                   "running transfer with zero speed")
  `AMRC_ASSERT_IMP(a_quo_range, state_q == amrc_pkg::S_FSUM, quo_q < amrc_pkg::TENTH_FULL,
                   "progress quotient out of range")
  `AMRC_ASSERT_NXT(a_fin_clears, out_load && fin_q, !active_q[$past(ax_q)],
                   "finished move left axis active")

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives start, sample and cancel commands into the axis move ramp controller
// under random idling and backpressure, predicts every speed command and
// compares each received transfer with the oldest one due
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] AXIS_NONE = 2'd3;
  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;
  localparam int SETTLE_CYCLES = 64;
  localparam int RX_HOLD_CYCLES = 600;

  localparam int unsigned SIGMOID_LUT [100] = '{
    1, 1, 1, 1, 2, 2, 2, 2, 3, 3,
    4, 4, 5, 6, 6, 7, 8, 10, 11, 13,
    15, 17, 19, 22, 26, 29, 34, 38, 44, 50,
    57, 65, 74, 85, 96, 109, 123, 139, 157, 177,
    198, 221, 246, 273, 302, 332, 364, 397, 430, 465,
    500, 535, 570, 603, 636, 668, 698, 727, 754, 779,
    802, 823, 843, 861, 877, 891, 904, 915, 926, 935,
    943, 950, 956, 962, 966, 971, 974, 978, 981, 983,
    985, 987, 989, 990, 992, 993, 994, 994, 995, 996,
    996, 997, 997, 998, 998, 998, 998, 999, 999, 999
  };

  typedef struct {
    logic [1:0]                   op;
    logic [amrc_pkg::AX_W-1:0]    ax;
    logic signed [31:0]           pos;
    logic signed [31:0]           tgt;
  } move_cmd_t;

  typedef struct {
    logic [amrc_pkg::AX_W-1:0]           ax;
    logic signed [amrc_pkg::SPEED_W-1:0] speed;
    logic                                finished;
  } speed_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [amrc_pkg::STALL_W-1:0] cfg_data_i;

  amrc_in_if  item_if ();
  amrc_out_if res_if ();

  axis_move_ramp_controller u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_if),
    .result_o   (res_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predicted controller state
  logic                         ax_active [amrc_pkg::AXES];
  longint                       ax_start  [amrc_pkg::AXES];
  longint                       ax_target [amrc_pkg::AXES];
  longint                       ax_prev   [amrc_pkg::AXES];
  logic [amrc_pkg::STALL_W-1:0] ax_stall  [amrc_pkg::AXES];
  logic [amrc_pkg::STALL_W-1:0] stall_limit_q;

  move_cmd_t  cmd_pending [$];
  speed_cmd_t speed_cmds_due [$];
  move_cmd_t  next_cmd;
  speed_cmd_t got_cmd;
  speed_cmd_t due_cmd;
  int pushed_cnt;
  int accepted_cnt;
  int mismatches;
  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold_left;
  logic rx_hold_arm;

  // stimulus shaping, one move per axis
  longint gen_start [amrc_pkg::AXES];
  longint gen_tgt   [amrc_pkg::AXES];
  longint gen_pos   [amrc_pkg::AXES];
  int     gen_left  [amrc_pkg::AXES];

  function automatic longint abs_diff(input longint a, input longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic longint clamp_pos(input longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  function automatic void compute_speed_cmd(input move_cmd_t c);
    longint p;
    longint moved;
    longint span;
    longint stride;
    longint tenth;
    bit ended;
    int unsigned mag;
    speed_cmd_t r;
    if (c.op == amrc_pkg::OP_CANCEL) begin
      for (int i = 0; i < amrc_pkg::AXES; i++) ax_active[i] = 1'b0;
      return;
    end
    if (c.op == OP_UNUSED || c.ax >= amrc_pkg::AXES) return;
    p = longint'(c.pos);
    if (c.op == amrc_pkg::OP_START) begin
      ax_active[c.ax] = 1'b1;
      ax_start[c.ax]  = p;
      ax_prev[c.ax]   = p;
      ax_target[c.ax] = longint'(c.tgt);
      return;
    end
    if (!ax_active[c.ax]) return;

    moved = abs_diff(p, ax_start[c.ax]);
    span  = abs_diff(ax_target[c.ax], ax_start[c.ax]);
    ended = 1'b0;
    tenth = 0;
    if (span == 0) begin
      ended = 1'b1;
    end else begin
      // left the start but did not move since the last sample
      if (p != ax_start[c.ax] && ax_prev[c.ax] == p) begin
        if (ax_stall[c.ax] != amrc_pkg::STALL_MAX) ax_stall[c.ax]++;
        if (ax_stall[c.ax] > stall_limit_q) ended = 1'b1;
      end else begin
        ax_stall[c.ax] = '0;
      end
      if (!ended) begin
        tenth  = (1000 * moved) / span;
        stride = abs_diff(p, ax_prev[c.ax]);
        if (stride + moved > span) begin
          if (tenth < 975) tenth = 975;
        end else if (stride + 2 * moved > span) begin
          if (tenth < 950) tenth = 950;
        end else if (stride + 4 * moved > span) begin
          if (tenth < 900) tenth = 900;
        end
        if (tenth >= 1000) ended = 1'b1;
      end
    end
    ax_prev[c.ax] = p;

    r.ax = c.ax;
    if (ended) begin
      ax_active[c.ax] = 1'b0;
      r.speed = '0;
      r.finished = 1'b1;
    end else begin
      if (tenth < 100) mag = SIGMOID_LUT[tenth];
      else if (tenth > 900) mag = SIGMOID_LUT[1000 - tenth];
      else mag = 1000;
      r.speed = (ax_target[c.ax] > ax_start[c.ax]) ? amrc_pkg::SPEED_W'(mag)
                                                   : -amrc_pkg::SPEED_W'(mag);
      r.finished = 1'b0;
    end
    speed_cmds_due.push_back(r);
  endfunction

  // command driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (item_if.valid && item_if.ready) begin
        compute_speed_cmd(next_cmd);
        accepted_cnt++;
      end
      if (!item_if.valid || item_if.ready) begin
        if (cmd_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          next_cmd = cmd_pending.pop_front();
          item_if.valid    <= 1'b1;
          item_if.op       <= next_cmd.op;
          item_if.axis     <= next_cmd.ax;
          item_if.position <= next_cmd.pos;
          item_if.target   <= next_cmd.tgt;
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (rx_hold_arm) begin
      rx_hold_left <= RX_HOLD_CYCLES;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  // speed command monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        got_cmd.ax       = res_if.out_axis;
        got_cmd.speed    = res_if.speed;
        got_cmd.finished = res_if.finished;
        if (speed_cmds_due.size() == 0) begin
          $error("unexpected speed transfer: out_axis %0d speed %0d finished %0d",
                 got_cmd.ax, got_cmd.speed, got_cmd.finished);
          mismatches++;
        end else begin
          due_cmd = speed_cmds_due.pop_front();
          if (got_cmd.ax !== due_cmd.ax) begin
            $error("out_axis: expected %0d, got %0d", due_cmd.ax, got_cmd.ax);
            mismatches++;
          end
          if (got_cmd.speed !== due_cmd.speed) begin
            $error("speed: expected %0d, got %0d", due_cmd.speed, got_cmd.speed);
            mismatches++;
          end
          if (got_cmd.finished !== due_cmd.finished) begin
            $error("finished: expected %0d, got %0d", due_cmd.finished, got_cmd.finished);
            mismatches++;
          end
        end
      end
      res_if.ready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic push_cmd(input logic [1:0] op, input logic [1:0] ax,
                          input longint pos, input longint tgt);
    move_cmd_t c;
    c.op  = op;
    c.ax  = ax;
    c.pos = 32'(pos);
    c.tgt = 32'(tgt);
    cmd_pending.push_back(c);
    pushed_cnt++;
  endtask

  task automatic settle();
    while (accepted_cnt != pushed_cnt || speed_cmds_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_stall_limit(input logic [amrc_pkg::STALL_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    stall_limit_q = v;
  endtask

  task automatic start_move(input logic [1:0] ax);
    longint s;
    longint t;
    int kind;
    kind = $urandom_range(99);
    s = longint'($signed($urandom()));
    if (kind < 55) begin
      t = s + ($urandom_range(1) ? 1 : -1) * longint'($urandom_range(0, 4000));
    end else if (kind < 83) begin
      t = longint'($signed($urandom()));
    end else if (kind < 91) begin
      t = s;
    end else begin
      s = $urandom_range(1) ? POS_MIN : POS_MAX;
      t = longint'($signed($urandom()));
    end
    t = clamp_pos(t);
    gen_start[ax] = s;
    gen_tgt[ax]   = t;
    gen_pos[ax]   = s;
    gen_left[ax]  = $urandom_range(2, 14);
    push_cmd(amrc_pkg::OP_START, ax, s, t);
  endtask

  task automatic sample_move(input logic [1:0] ax);
    longint p;
    int roll;
    int reps;
    roll = $urandom_range(99);
    p = gen_pos[ax];
    reps = 1;
    if (roll < 20) begin
      // axis sits still for a few samples
      reps = $urandom_range(1, 5);
    end else if (roll < 26) begin
      p = gen_tgt[ax] + longint'($urandom_range(0, 50)) - 25;
    end else if (roll < 30) begin
      p = gen_pos[ax] - (gen_tgt[ax] - gen_pos[ax]) / 4;
    end else if (roll < 33) begin
      p = longint'($signed($urandom()));
    end else if (roll < 36) begin
      p = gen_start[ax];
    end else begin
      p = gen_pos[ax] + (gen_tgt[ax] - gen_pos[ax]) / gen_left[ax]
          + longint'($urandom_range(0, 6)) - 3;
    end
    p = clamp_pos(p);
    gen_pos[ax] = p;
    gen_left[ax]--;
    repeat (reps) push_cmd(amrc_pkg::OP_SAMPLE, ax, p, $urandom());
  endtask

  task automatic random_traffic(input int count);
    int roll;
    logic [1:0] ax;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        push_cmd(OP_UNUSED, 2'($urandom()), $urandom(), $urandom());
      end else if (roll < 5) begin
        push_cmd(amrc_pkg::OP_CANCEL, 2'($urandom()), $urandom(), $urandom());
        for (int i = 0; i < amrc_pkg::AXES; i++) gen_left[i] = 0;
      end else if (roll < 8) begin
        push_cmd(2'($urandom_range(0, 1)), AXIS_NONE, $urandom(), $urandom());
      end else begin
        ax = 2'($urandom_range(0, amrc_pkg::AXES - 1));
        if (gen_left[ax] == 0) start_move(ax);
        else sample_move(ax);
      end
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_data_i       = '0;
    item_if.valid    = 1'b0;
    item_if.op       = amrc_pkg::OP_START;
    item_if.axis     = '0;
    item_if.position = '0;
    item_if.target   = '0;
    res_if.ready     = 1'b0;
    rx_hold_arm      = 1'b0;
    rx_hold_left     = 0;
    pushed_cnt       = 0;
    accepted_cnt     = 0;
    mismatches       = 0;
    tx_idle_pct      = 30;
    rx_idle_pct      = 30;
    stall_limit_q    = amrc_pkg::STALL_RESET;
    for (int i = 0; i < amrc_pkg::AXES; i++) begin
      ax_active[i] = 1'b0;
      ax_stall[i]  = '0;
      ax_start[i]  = 0;
      ax_target[i] = 0;
      ax_prev[i]   = 0;
      gen_left[i]  = 0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part on the reset stall limit
    push_cmd(amrc_pkg::OP_SAMPLE, 2'd0, 0, 0);                      // inactive axis
    push_cmd(amrc_pkg::OP_START,  2'd0, POS_MIN, POS_MAX);          // longest move
    push_cmd(amrc_pkg::OP_SAMPLE, 2'd0, POS_MIN, 0);
    push_cmd(amrc_pkg::OP_SAMPLE, 2'd0, POS_MIN + (64'sd1 << 28), 0);
    push_cmd(amrc_pkg::OP_SAMPLE, 2'd0, 0, 0);                      // big stride, braking
    push_cmd(amrc_pkg::OP_SAMPLE, 2'd0, POS_MAX, 0);
    push_cmd(amrc_pkg::OP_SAMPLE, 2'd0, 0, 0);                      // move already ended
    push_cmd(amrc_pkg::OP_START,  2'd1, 5, 5);                      // zero length
    push_cmd(amrc_pkg::OP_SAMPLE, 2'd1, 7, 0);
    push_cmd(amrc_pkg::OP_START,  2'd2, POS_MAX, POS_MIN);          // negative direction
    push_cmd(amrc_pkg::OP_SAMPLE, 2'd2, POS_MAX - (64'sd1 << 30), 0);
    push_cmd(amrc_pkg::OP_SAMPLE, 2'd2, POS_MAX - (64'sd1 << 30), 0);
    push_cmd(amrc_pkg::OP_SAMPLE, 2'd2, POS_MIN, 0);
    push_cmd(amrc_pkg::OP_START,  2'd0, 1000, 0);
    push_cmd(amrc_pkg::OP_SAMPLE, 2'd0, 900, 0);                    // full speed band
    push_cmd(amrc_pkg::OP_SAMPLE, 2'd0, 450, 0);
    push_cmd(amrc_pkg::OP_START,  AXIS_NONE, 1, 2);
    push_cmd(amrc_pkg::OP_SAMPLE, AXIS_NONE, 1, 2);
    push_cmd(OP_UNUSED, 2'd1, -1, -1);
    push_cmd(amrc_pkg::OP_START,  2'd1, 0, 100);
    push_cmd(amrc_pkg::OP_CANCEL, AXIS_NONE, 0, 0);
    push_cmd(amrc_pkg::OP_SAMPLE, 2'd1, 50, 0);                     // cancelled
    push_cmd(amrc_pkg::OP_START,  2'd2, -1, 1);
    push_cmd(amrc_pkg::OP_SAMPLE, 2'd2, 1, 0);
    random_traffic(90);
    // sender waits for every outstanding speed command
    settle();
    random_traffic(90);
    settle();

    write_stall_limit('0);
    push_cmd(amrc_pkg::OP_START,  2'd1, 0, 1000);
    push_cmd(amrc_pkg::OP_SAMPLE, 2'd1, 10, 0);
    push_cmd(amrc_pkg::OP_SAMPLE, 2'd1, 10, 0);                     // first stall ends it
    push_cmd(amrc_pkg::OP_START,  2'd2, 50, 60);
    push_cmd(amrc_pkg::OP_SAMPLE, 2'd2, 50, 0);                     // still at start
    random_traffic(190);
    settle();

    write_stall_limit(amrc_pkg::STALL_W'(65534));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_traffic(220);
    settle();
    tx_idle_pct = 30;
    rx_idle_pct = 30;

    write_stall_limit(amrc_pkg::STALL_W'(3));
    push_cmd(amrc_pkg::OP_START, 2'd0, 0, 64'sd1 << 30);
    for (int k = 1; k <= 40; k++) push_cmd(amrc_pkg::OP_SAMPLE, 2'd0, k * 1000, 0);
    gen_left[0] = 0;
    @(posedge clk_i);
    rx_hold_arm <= 1'b1;
    @(posedge clk_i);
    rx_hold_arm <= 1'b0;
    random_traffic(220);
    settle();

    write_stall_limit(amrc_pkg::STALL_W'($urandom_range(1, 20)));
    random_traffic(220);
    settle();

    write_stall_limit(amrc_pkg::STALL_W'($urandom_range(0, 65534)));
    random_traffic(170);
    settle();

    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
